/* rtl/core/pcc_pkg.sv */
// shared types and constants for the polygon convexity checker
// no dependencies; used by every module of the block by scoped names
package pcc_pkg;

    // three vertex triples can be classed for one vertex: the running one and two wrap-around
    localparam int unsigned N_TRI       = 3;
    // four coordinate differences describe one triple
    localparam int unsigned N_DIFF      = 4 * N_TRI;
    // two products per triple
    localparam int unsigned N_PROD      = 2 * N_TRI;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // triple slots within a job
    localparam int unsigned TRI_RUN     = 0;
    localparam int unsigned TRI_WRAP_A  = 1;
    localparam int unsigned TRI_WRAP_B  = 2;

    // control part of one job passed from front to back
    typedef struct packed {
        logic [N_TRI-1:0] tri_valid;
        logic             last;
    } t_job_ctl;

endpackage

/* rtl/core/pcc_front.sv */
// front end: takes vertices, tracks polygon history and forms coordinate differences
// depends on pcc_pkg
module pcc_front #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    input  logic                                              i_full,
    input  logic signed [COORD_WIDTH-1:0]                     i_vx,
    input  logic signed [COORD_WIDTH-1:0]                     i_vy,
    input  logic                                              i_final_vertex,
    output logic                                              o_push,
    output pcc_pkg::t_job_ctl                                 o_ctl,
    output logic        [pcc_pkg::N_DIFF*(COORD_WIDTH+1)-1:0] o_diffs
);

    localparam int unsigned DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic signed [COORD_WIDTH-1:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    logic        [1:0]             r_seen;
    logic        [1:0]             n_seen;

    logic signed [DW-1:0] w_in_x, w_in_y, w_fx, w_fy, w_sx, w_sy;
    logic signed [DW-1:0] w_ox, w_oy, w_nx, w_ny;
    logic signed [DW-1:0] w_d [pcc_pkg::N_DIFF];
    logic                 w_have_two;

    assign o_push     = i_valid && !i_full;
    assign w_have_two = r_seen[1];

    // sign extend by one bit so that differences are exact
    assign w_in_x = {i_vx[COORD_WIDTH-1], i_vx};
    assign w_in_y = {i_vy[COORD_WIDTH-1], i_vy};
    assign w_fx   = {r_first_x[COORD_WIDTH-1], r_first_x};
    assign w_fy   = {r_first_y[COORD_WIDTH-1], r_first_y};
    assign w_sx   = {r_second_x[COORD_WIDTH-1], r_second_x};
    assign w_sy   = {r_second_y[COORD_WIDTH-1], r_second_y};
    assign w_ox   = {r_older_x[COORD_WIDTH-1], r_older_x};
    assign w_oy   = {r_older_y[COORD_WIDTH-1], r_older_y};
    assign w_nx   = {r_newer_x[COORD_WIDTH-1], r_newer_x};
    assign w_ny   = {r_newer_y[COORD_WIDTH-1], r_newer_y};

    // per triple (a, b, c): bx-ax, cy-ay, by-ay, cx-ax
    // running triple: older, newer, incoming
    assign w_d[0]  = w_nx - w_ox;
    assign w_d[1]  = w_in_y - w_oy;
    assign w_d[2]  = w_ny - w_oy;
    assign w_d[3]  = w_in_x - w_ox;
    // first wrap: newer, incoming, first
    assign w_d[4]  = w_in_x - w_nx;
    assign w_d[5]  = w_fy - w_ny;
    assign w_d[6]  = w_in_y - w_ny;
    assign w_d[7]  = w_fx - w_nx;
    // second wrap: incoming, first, second
    assign w_d[8]  = w_fx - w_in_x;
    assign w_d[9]  = w_sy - w_in_y;
    assign w_d[10] = w_fy - w_in_y;
    assign w_d[11] = w_sx - w_in_x;

    always_comb begin
        for (int k = 0; k < pcc_pkg::N_DIFF; k++) begin
            o_diffs[k*DW +: DW] = w_d[k];
        end
    end

    always_comb begin
        o_ctl                                  = '0;
        o_ctl.tri_valid[pcc_pkg::TRI_RUN]      = w_have_two;
        o_ctl.tri_valid[pcc_pkg::TRI_WRAP_A]   = w_have_two && i_final_vertex;
        o_ctl.tri_valid[pcc_pkg::TRI_WRAP_B]   = w_have_two && i_final_vertex;
        o_ctl.last                             = i_final_vertex;
    end

    assign n_seen = (r_seen == 2'd3) ? r_seen : r_seen + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_second_x <= '0;
            r_second_y <= '0;
            r_older_x  <= '0;
            r_older_y  <= '0;
            r_newer_x  <= '0;
            r_newer_y  <= '0;
        end else if (o_push) begin
            if (i_final_vertex) begin
                r_seen     <= '0;
                r_first_x  <= '0;
                r_first_y  <= '0;
                r_second_x <= '0;
                r_second_y <= '0;
                r_older_x  <= '0;
                r_older_y  <= '0;
                r_newer_x  <= '0;
                r_newer_y  <= '0;
            end else begin
                if (r_seen == 2'd0) begin
                    r_first_x <= i_vx;
                    r_first_y <= i_vy;
                end
                if (r_seen == 2'd1) begin
                    r_second_x <= i_vx;
                    r_second_y <= i_vy;
                end
                r_older_x <= r_newer_x;
                r_older_y <= r_newer_y;
                r_newer_x <= i_vx;
                r_newer_y <= i_vy;
                r_seen    <= n_seen;
            end
        end
    end

`ifndef SYNTHESIS
    // a closed polygon leaves no history behind
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && i_final_vertex |=> r_seen == 2'd0)
        else $error("front history not cleared after final vertex");
`endif

endmodule

/* rtl/core/pcc_queue.sv */
// short job queue between front end and back end
// depends on pcc_pkg for depth and pointer widths
module pcc_queue #(
    parameter int unsigned DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0]          r_mem [pcc_pkg::QUEUE_DEPTH];
    logic [pcc_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [pcc_pkg::QCNT_W-1:0] r_count;
    logic                       w_pop;

    assign o_full     = (r_count == pcc_pkg::QCNT_W'(pcc_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];
    assign w_pop      = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pcc_pkg::QCNT_W'(pcc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* rtl/core/pcc_back.sv */
// back end: cross product multipliers, turn classing, sign accumulation, result register
// depends on pcc_pkg
module pcc_back #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_job_valid,
    input  pcc_pkg::t_job_ctl                                 i_ctl,
    input  logic        [pcc_pkg::N_DIFF*(COORD_WIDTH+1)-1:0] i_diffs,
    output logic                                              o_pop,
    output logic                                              o_valid,
    input  logic                                              i_stall,
    output logic                                              o_convex
);

    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned PW = 2 * DW;

    logic                 w_adv;
    logic signed [DW-1:0] w_d [pcc_pkg::N_DIFF];
    logic signed [PW-1:0] n_prod [pcc_pkg::N_PROD];

    logic                     r_m_valid;
    pcc_pkg::t_job_ctl        r_m_ctl;
    logic signed [PW-1:0]     r_prod [pcc_pkg::N_PROD];

    logic                      r_saw_pos, r_saw_nonpos;
    logic [pcc_pkg::N_TRI-1:0] w_pos, w_nonpos;
    logic                      w_any_pos, w_any_nonpos;
    logic                      r_o_valid, r_o_convex;

    // whole back end moves unless a result sits unclaimed
    assign w_adv = !r_o_valid || !i_stall;
    assign o_pop = w_adv;

    always_comb begin
        for (int k = 0; k < pcc_pkg::N_DIFF; k++) begin
            w_d[k] = i_diffs[k*DW +: DW];
        end
        for (int t = 0; t < pcc_pkg::N_TRI; t++) begin
            n_prod[2*t]   = w_d[4*t] * w_d[4*t+1];
            n_prod[2*t+1] = w_d[4*t+2] * w_d[4*t+3];
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_ctl <= i_ctl;
            for (int p = 0; p < pcc_pkg::N_PROD; p++) begin
                r_prod[p] <= n_prod[p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= i_job_valid;
        end
    end

    // turn class: positive when the cross product is above zero
    always_comb begin
        for (int t = 0; t < pcc_pkg::N_TRI; t++) begin
            w_pos[t]    = r_m_ctl.tri_valid[t] && (r_prod[2*t] > r_prod[2*t+1]);
            w_nonpos[t] = r_m_ctl.tri_valid[t] && !(r_prod[2*t] > r_prod[2*t+1]);
        end
    end

    assign w_any_pos    = r_saw_pos || (|w_pos);
    assign w_any_nonpos = r_saw_nonpos || (|w_nonpos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saw_pos    <= 1'b0;
            r_saw_nonpos <= 1'b0;
            r_o_valid    <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_m_valid && r_m_ctl.last;
            if (r_m_valid) begin
                if (r_m_ctl.last) begin
                    r_saw_pos    <= 1'b0;
                    r_saw_nonpos <= 1'b0;
                end else begin
                    r_saw_pos    <= w_any_pos;
                    r_saw_nonpos <= w_any_nonpos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_m_valid && r_m_ctl.last) begin
            r_o_convex <= !(w_any_pos && w_any_nonpos);
        end
    end

    assign o_valid  = r_o_valid;
    assign o_convex = r_o_convex;

`ifndef SYNTHESIS
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_m_valid && r_m_ctl.last |=> !r_saw_pos && !r_saw_nonpos)
        else $error("turn flags not cleared after polygon close");
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_m_valid && r_m_ctl.last))
        else $error("result without a final vertex");
`endif

endmodule

/* rtl/core/polygon_convexity_check.sv */
// top level of the polygon convexity checker
// depends on pcc_pkg, pcc_front, pcc_queue and pcc_back
//
// usage
//  - input channel: one vertex per transaction on i_vx / i_vy (signed), with
//    i_final_vertex set on the last vertex of a polygon; taken at a clock edge
//    where i_valid is high and o_stall is low
//  - output channel: one transaction per polygon, o_convex on o_valid, taken
//    when i_stall is low; nothing is emitted for vertices that are not final
//  - a polygon of fewer than three vertices reports convex; a zero cross
//    product counts with the negative turns
//  - throughput: one vertex per clock while i_stall stays low; from the third vertex on
//    each needs one cross product, the final one three, all by six parallel multipliers
//  - o_valid rises once the final vertex has passed the job queue, the multiply
//    stage and the result register
//  - a four-deep job queue sits between front end and back end; o_stall is
//    high only while that queue is full
//  - when the receiver stalls, the result holds in its register and the back
//    end freezes; vertices still enter until the queue fills
//  - reset (synchronous, active low) clears history, turn flags, queue and output valid
module polygon_convexity_check #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_vx,
    input  logic signed [COORD_WIDTH-1:0] i_vy,
    input  logic                          i_final_vertex,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_convex
);

    localparam int unsigned DIFF_W = pcc_pkg::N_DIFF * (COORD_WIDTH + 1);
    localparam int unsigned CTL_W  = $bits(pcc_pkg::t_job_ctl);
    localparam int unsigned JOB_W  = CTL_W + DIFF_W;

    // front to queue
    logic                    w_push;
    pcc_pkg::t_job_ctl       w_f_ctl;
    logic [DIFF_W-1:0]       w_f_diffs;
    logic                    w_full;

    // queue to back
    logic                    w_pop;
    logic                    w_nonempty;
    logic [JOB_W-1:0]        w_q_data;
    pcc_pkg::t_job_ctl       w_b_ctl;
    logic [DIFF_W-1:0]       w_b_diffs;

    assign o_stall   = w_full;
    assign w_b_ctl   = w_q_data[JOB_W-1 -: CTL_W];
    assign w_b_diffs = w_q_data[DIFF_W-1:0];

    // vertex history and difference forming
    pcc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_full         (w_full),
        .i_vx           (i_vx),
        .i_vy           (i_vy),
        .i_final_vertex (i_final_vertex),
        .o_push         (w_push),
        .o_ctl          (w_f_ctl),
        .o_diffs        (w_f_diffs)
    );

    // decoupling queue
    pcc_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     ({w_f_ctl, w_f_diffs}),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_data     (w_q_data)
    );

    // products, classing and result register
    pcc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_nonempty),
        .i_ctl       (w_b_ctl),
        .i_diffs     (w_b_diffs),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_convex    (o_convex)
    );

endmodule
